// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the softmax block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMX_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMX_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smx_pkg.sv -----
// Package for the softmax block: widths, constants, command/status types and
// the 2^(-k/16) table. No dependencies.
package smx_pkg;

  localparam int MaxLen = 64;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int CntW   = $clog2(MaxLen + 1);
  localparam int ScoreW = 16;
  localparam int ProbW  = 16;
  localparam int ExpW   = 17;
  localparam int SumW   = 23;
  localparam int RecipW = 17;

  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [15:0] Ln2Q16   = 16'd45426;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             clr_vec;
    logic             sum_clr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             rd_last;
    logic             out_pass;
    logic             div_start;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            pipe_busy;
    logic            div_busy;
    logic            out_valid;
  } status_t;

  // 2^(-k/16) in Q16.
  function automatic logic [16:0] exp2_tab(input logic [3:0] k);
    logic [16:0] v;
    begin
      case (k)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd62757;
        4'd2:    v = 17'd60097;
        4'd3:    v = 17'd57548;
        4'd4:    v = 17'd55109;
        4'd5:    v = 17'd52773;
        4'd6:    v = 17'd50535;
        4'd7:    v = 17'd48393;
        4'd8:    v = 17'd46341;
        4'd9:    v = 17'd44376;
        4'd10:   v = 17'd42495;
        4'd11:   v = 17'd40693;
        4'd12:   v = 17'd38968;
        4'd13:   v = 17'd37316;
        4'd14:   v = 17'd35734;
        default: v = 17'd34219;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- rtl/smx_if.sv -----
// Stream interfaces for the softmax block: score words in, probability words out.
// Depends on smx_pkg for the field widths.
interface smx_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [smx_pkg::ScoreW-1:0] score;
  logic                           final_element;

  modport source (output valid, output score, output final_element, input ready);
  modport sink   (input valid, input score, input final_element, output ready);
endinterface

interface smx_out_if;
  logic                       valid;
  logic                       ready;
  logic [smx_pkg::ProbW-1:0]  probability;
  logic                       final_result;

  modport source (output valid, output probability, output final_result, input ready);
  modport sink   (input valid, input probability, input final_result, output ready);
endinterface

// ----- rtl/smx_recip_div.sv -----
// Bit-serial restoring divider that forms floor(2^32 / sum) as a Q16 reciprocal.
// Depends on smx_pkg for widths.
module smx_recip_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smx_pkg::SumW-1:0]    divisor,
  output logic                        busy,
  output logic [smx_pkg::RecipW-1:0]  recip
);

  logic [smx_pkg::SumW:0]        rem_r, rem_nxt;
  logic [smx_pkg::RecipW-1:0]    quo_r, quo_nxt;
  logic [5:0]                    bit_r, bit_nxt;
  logic                          busy_r, busy_nxt;
  logic                          zero_r, zero_nxt;
  logic [smx_pkg::SumW:0]        trial;
  logic                          dbit;
  logic                          qbit;

  // One quotient bit per cycle, dividend bit 32 set and all others clear.
  always_comb begin
    dbit    = (bit_r == 6'd32);
    trial   = {rem_r[smx_pkg::SumW-1:0], dbit};
    qbit    = (trial >= {1'b0, divisor});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = '0;
      bit_nxt  = 6'd32;
      busy_nxt = 1'b1;
      zero_nxt = (divisor == '0);
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, divisor}) : trial;
      quo_nxt = {quo_r[smx_pkg::RecipW-2:0], qbit};
      bit_nxt = bit_r - 6'd1;
      if (bit_r == 6'd0) begin
        busy_nxt = 1'b0;
        if (zero_r) quo_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      quo_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      quo_r  <= quo_nxt;
    end
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
    zero_r <= zero_nxt;
  end

  assign busy  = busy_r;
  assign recip = quo_r;

endmodule

// ----- rtl/smx_datapath.sv -----
// Datapath of the softmax block: score memory, running max, exp pipeline,
// sum, reciprocal divider and output word register. Depends on smx_pkg.
module smx_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smx_pkg::cmd_t                     cmd,
  output smx_pkg::status_t                  status,
  input  logic signed [smx_pkg::ScoreW-1:0] in_score,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [smx_pkg::ProbW-1:0]         out_probability,
  output logic                              out_final
);

  localparam logic [smx_pkg::CntW-1:0] MaxLenC = smx_pkg::CntW'(smx_pkg::MaxLen);

  logic signed [smx_pkg::ScoreW-1:0] mem [smx_pkg::MaxLen];

  logic signed [smx_pkg::ScoreW-1:0] max_r;
  logic [smx_pkg::CntW-1:0]          cnt_r;
  logic [smx_pkg::SumW-1:0]          sum_r;

  logic                              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic                              l0_r, l1_r, l2_r, l3_r, l4_r;
  logic signed [smx_pkg::ScoreW-1:0] rd_r;
  logic [32:0]                       t1_r;
  logic [11:0]                       a2_r;
  logic [3:0]                        k2_r, k3_r;
  logic [4:0]                        n2_r, n3_r;
  logic                              z2_r, z3_r;
  logic [16:0]                       f3_r;
  logic [smx_pkg::ExpW-1:0]          e4_r;

  logic                              store_en;
  logic [16:0]                       diff;
  logic [35:0]                       aprod;
  logic [23:0]                       asq;
  logic [33:0]                       vprod;
  logic [16:0]                       vval;
  logic [33:0]                       pprod;
  logic [smx_pkg::ProbW-1:0]         psat;

  logic                              out_valid_r;
  logic [smx_pkg::ProbW-1:0]         out_prob_r;
  logic                              out_last_r;

  logic                              div_busy;
  logic [smx_pkg::RecipW-1:0]        recip;

  assign store_en = cmd.load && (cnt_r < MaxLenC);

  // Score memory: written on load while not full, read one word per issue.
  always_ff @(posedge clk) begin
    if (store_en) mem[cnt_r[smx_pkg::AddrW-1:0]] <= in_score;
    if (cmd.rd_en) rd_r <= mem[cmd.rd_addr];
  end

  // Element count and running maximum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      max_r <= 16'sh8000;
    end else if (cmd.clr_vec) begin
      cnt_r <= '0;
      max_r <= 16'sh8000;
    end else if (store_en) begin
      cnt_r <= cnt_r + 1'b1;
      if (in_score > max_r) max_r <= in_score;
    end
  end

  // Exp pipeline arithmetic.
  always_comb begin
    diff  = 17'({max_r[15], max_r}) - 17'({rd_r[15], rd_r});
    aprod = 36'(t1_r[19:0]) * 36'(smx_pkg::Ln2Q16);
    asq   = 24'(a2_r) * 24'(a2_r);
    vprod = 34'(smx_pkg::exp2_tab(k3_r)) * 34'(f3_r);
    vval  = vprod[32:16];
    pprod = 34'(e4_r) * 34'(recip);
    psat  = (pprod[33:32] != 2'b00) ? 16'hFFFF : pprod[31:16];
  end

  // Pipeline registers: stage one t = m*log2e, two a, three f, four e.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.rd_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    l0_r <= cmd.rd_last;
    l1_r <= l0_r;
    l2_r <= l1_r;
    l3_r <= l2_r;
    l4_r <= l3_r;
    t1_r <= 33'(diff[15:0]) * 33'(smx_pkg::Log2eQ16);
    a2_r <= aprod[35:24];
    k2_r <= t1_r[23:20];
    n2_r <= t1_r[28:24];
    z2_r <= (t1_r[32:24] >= 9'd17);
    f3_r <= 17'd65536 - 17'(a2_r) + 17'(asq[23:17]);
    k3_r <= k2_r;
    n3_r <= n2_r;
    z3_r <= z2_r;
    e4_r <= z3_r ? '0 : (vval >> n3_r);
  end

  // Sum of exponentials during the sum pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (v4_r && !cmd.out_pass) begin
      sum_r <= sum_r + smx_pkg::SumW'(e4_r);
    end
  end

  smx_recip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (sum_r),
    .busy    (div_busy),
    .recip   (recip)
  );

  // Output word register, loaded from the last exp stage in the scale pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v4_r && cmd.out_pass) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (v4_r && cmd.out_pass) begin
      out_prob_r <= psat;
      out_last_r <= l4_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_final       = out_last_r;

  assign status.count     = cnt_r;
  assign status.pipe_busy = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign status.div_busy  = div_busy;
  assign status.out_valid = out_valid_r;

endmodule

// ----- rtl/smx_ctrl.sv -----
// Controller of the softmax block: load, sum, divide and scale passes.
// Depends on smx_pkg for the command and status types.
module smx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final,
  output logic              in_ready,
  input  logic              out_ready,
  input  smx_pkg::status_t  status,
  output smx_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SUM     = 3'd1;
  localparam logic [2:0] ST_SUMWAIT = 3'd2;
  localparam logic [2:0] ST_DIV     = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;
  localparam logic [2:0] ST_DRAIN   = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [smx_pkg::AddrW-1:0] idx_r, idx_nxt;
  logic                      accept;
  logic                      at_last;
  logic                      out_free;

  assign accept   = in_valid && (state_r == ST_LOAD);
  assign at_last  = ({1'b0, idx_r} == (status.count - 1'b1));
  assign out_free = !status.pipe_busy && (!status.out_valid || out_ready);

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.rd_addr   = idx_r;
    cmd.load      = accept;
    cmd.out_pass  = (state_r == ST_OUT) || (state_r == ST_DRAIN);
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_final) begin
          cmd.sum_clr = 1'b1;
          idx_nxt     = '0;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.rd_en = 1'b1;
        if (at_last) state_nxt = ST_SUMWAIT;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_SUMWAIT: begin
        if (!status.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_last = at_last;
          if (at_last) state_nxt = ST_DRAIN;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.clr_vec = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready = (state_r == ST_LOAD);

endmodule

// ----- rtl/softmax_vector.sv -----
// Top level of the softmax block: controller plus datapath.
// Depends on smx_pkg, smx_if, smx_ctrl and smx_datapath.
//
//   Channel  Dir  Word contents
//   in_ch    in   score (signed Q8.8), final_element
//   out_ch   out  probability (unsigned Q0.16), final_result
//
// Each score word is taken while in_ch.ready is high. After the final word of a
// vector the block runs a sum pass over its elements, a bit-serial reciprocal
// divide, then a scale pass that reads each word once the exp pipeline is empty.
// Reset is synchronous and clears the vector; in_ch.ready is low while a vector
// is being computed, and a stalled out_ch holds the scale pass.
module softmax_vector (
  input  logic        clk,
  input  logic        rst_n,
  smx_in_if.sink      in_ch,
  smx_out_if.source   out_ch
);

  smx_pkg::cmd_t    cmd;
  smx_pkg::status_t status;
  logic             in_ready;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_final  (in_ch.final_element),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  smx_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_score        (in_ch.score),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_probability (out_ch.probability),
    .out_final       (out_ch.final_result)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- rtl/smx_checker.sv -----
// Port-level checker for the softmax block, bound to softmax_vector.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module smx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_probability,
  input logic        out_final
);

  // A stalled result word stays up and unchanged.
  `SMX_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out word dropped")
  `SMX_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_probability), "out word changed")

  // Closing a vector stops input until its results are computed.
  `SMX_ASSERT_NXT(a_close_blocks, in_valid && in_ready && in_final, !in_ready, "input after close")

  // The final word of a vector is not followed at once by another word.
  `SMX_ASSERT_NXT(a_final_gap, out_valid && out_ready && out_final, !out_valid, "word after final")

endmodule

bind softmax_vector smx_checker u_smx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_final        (in_ch.final_element),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_probability (out_ch.probability),
  .out_final       (out_ch.final_result)
);
